@@ rtl/core/htld_pkg.sv @@
// Shared types and codes for the Huffman tree load and decode core.
package htld_pkg;

    // Token codes carried on the operation field.
    typedef enum logic [1:0] {
        OP_RESTART  = 2'd0,
        OP_INTERNAL = 2'd1,
        OP_LEAF     = 2'd2,
        OP_BIT      = 2'd3
    } op_t;

    // Status codes returned with every result word.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EARLY_BIT = 2'd1,
        STATUS_TREE_ERR  = 2'd2
    } status_t;

    localparam int SYMBOL_W = 8;

    // Leaf flag and symbol as stored in the node table.
    typedef struct packed {
        logic                is_leaf;
        logic [SYMBOL_W-1:0] symbol;
    } node_entry_t;

endpackage

@@ rtl/core/huffman_tree_load_and_decode_core.sv @@
// Huffman decoder core: pre-order tree loader, node table and bit-serial tree walk.
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------------------
//  item    | item_valid / item_stall   | operation, leaf_symbol, code_bit
//  result  | result_valid / result_stall | decoded_symbol, symbol_valid, tree_ready, status
//
// Every word lands in an input register and its result in an output register, so a new
// word is taken while a finished result still waits. Tree tokens, restarts, early bits
// and bits under a leaf root complete once the output register is free. A bit that walks
// the tree also waits for the registered read of the child node from the node table.
// Reset clears the control state; the node table and pending stack hold no reset value
// and are only read at entries the current tree has written.
// A stalled result holds the output register, and the input register then holds its word.
module huffman_tree_load_and_decode_core
    import htld_pkg::*;
#(
    parameter int NODE_CAPACITY  = 511,
    parameter int STACK_CAPACITY = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          operation,
    input  logic [SYMBOL_W-1:0] leaf_symbol,
    input  logic                code_bit,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [SYMBOL_W-1:0] decoded_symbol,
    output logic                symbol_valid,
    output logic                tree_ready,
    output logic [1:0]          status
);

    // Index and count widths.
    localparam int NAW = $clog2(NODE_CAPACITY);
    localparam int NCW = $clog2(NODE_CAPACITY + 1);
    localparam int SAW = (STACK_CAPACITY > 1) ? $clog2(STACK_CAPACITY) : 1;
    localparam int SCW = $clog2(STACK_CAPACITY + 1);

    localparam logic [NCW-1:0] NODE_CAP_C  = NCW'(NODE_CAPACITY);
    localparam logic [NAW:0]   NODE_CAP_W  = (NAW + 1)'(NODE_CAPACITY);
    localparam logic [SCW-1:0] STACK_CAP_C = SCW'(STACK_CAPACITY);

    // Input register.
    logic                in_valid_reg, in_valid_next;
    op_t                 op_reg;
    logic [SYMBOL_W-1:0] sym_reg;
    logic                bit_reg;

    // Output register.
    logic                result_valid_reg, result_valid_next;
    logic [SYMBOL_W-1:0] dsym_reg, dsym_next;
    logic                svalid_reg, svalid_next;
    logic                tready_reg;
    status_t             status_reg, status_next;

    // Tree and walk state.
    logic [NCW-1:0]      next_free_reg, next_free_next;
    logic [SCW-1:0]      count_reg, count_next;
    logic                tree_done_reg, tree_done_next;
    logic                last_leaf_reg, last_leaf_next;
    logic                root_leaf_reg, root_leaf_next;
    logic [SYMBOL_W-1:0] root_sym_reg, root_sym_next;
    logic [NAW-1:0]      root_right_reg, root_right_next;
    logic [NAW-1:0]      walk_reg, walk_next;
    logic [NAW-1:0]      cur_right_reg, cur_right_next;
    logic                wait_reg, wait_next;

    // Memories and their registered read data.
    node_entry_t         node_mem [NODE_CAPACITY];
    logic [NAW-1:0]      right_mem [NODE_CAPACITY];
    logic [NAW-1:0]      stack_mem [STACK_CAPACITY];
    node_entry_t         rd_node_reg;
    logic [NAW-1:0]      rd_right_reg;
    logic [NAW-1:0]      stack_top_reg;

    // Control and write-port signals.
    logic                out_free, need_mem, complete, issue;
    logic [NAW-1:0]      walk_right;
    logic [NAW:0]        child_raw;
    logic [NAW-1:0]      child;
    logic [NAW-1:0]      n_idx;
    logic                attach;
    logic                node_we, right_we, stack_we;
    node_entry_t         node_wd;
    logic [SAW-1:0]      stack_wa, stack_ra;
    logic [SCW-1:0]      count_dec;

    // Handshake and sequencing of the input word.
    assign out_free   = !result_valid_reg || !result_stall;
    assign need_mem   = (op_reg == OP_BIT) && tree_done_reg && !root_leaf_reg;
    assign complete   = in_valid_reg && out_free && (!need_mem || wait_reg);
    assign issue      = in_valid_reg && need_mem && !wait_reg;
    assign item_stall = in_valid_reg && !complete;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && !item_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (complete)
        begin
            in_valid_next = 1'b0;
        end

        wait_next = wait_reg;
        if (issue)
        begin
            wait_next = 1'b1;
        end
        else if (complete)
        begin
            wait_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (complete)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Child of the current walk position; an index past the table goes back to the root.
    assign walk_right = (walk_reg == '0) ? root_right_reg : cur_right_reg;
    assign child_raw  = bit_reg ? {1'b0, walk_right} : ({1'b0, walk_reg} + 1'b1);
    assign child      = (child_raw >= NODE_CAP_W) ? '0 : child_raw[NAW-1:0];

    assign n_idx     = next_free_reg[NAW-1:0];
    assign attach    = last_leaf_reg && (count_reg != '0);
    assign count_dec = count_reg - 1'b1;

    // Token processing and walk step.
    always_comb
    begin
        next_free_next  = next_free_reg;
        count_next      = count_reg;
        tree_done_next  = tree_done_reg;
        last_leaf_next  = last_leaf_reg;
        root_leaf_next  = root_leaf_reg;
        root_sym_next   = root_sym_reg;
        root_right_next = root_right_reg;
        walk_next       = walk_reg;
        cur_right_next  = cur_right_reg;
        dsym_next       = '0;
        svalid_next     = 1'b0;
        status_next     = STATUS_OK;
        node_we         = 1'b0;
        node_wd         = '{is_leaf: 1'b0, symbol: '0};
        right_we        = 1'b0;
        stack_we        = 1'b0;
        stack_wa        = count_reg[SAW-1:0];

        if (complete)
        begin
            unique case (op_reg)
                OP_RESTART:
                begin
                    next_free_next = '0;
                    count_next     = '0;
                    tree_done_next = 1'b0;
                    last_leaf_next = 1'b0;
                    walk_next      = '0;
                end
                OP_BIT:
                begin
                    if (!tree_done_reg)
                    begin
                        status_next = STATUS_EARLY_BIT;
                    end
                    else if (root_leaf_reg)
                    begin
                        dsym_next   = root_sym_reg;
                        svalid_next = 1'b1;
                        walk_next   = '0;
                    end
                    else if (rd_node_reg.is_leaf)
                    begin
                        dsym_next   = rd_node_reg.symbol;
                        svalid_next = 1'b1;
                        walk_next   = '0;
                    end
                    else
                    begin
                        walk_next      = child;
                        cur_right_next = rd_right_reg;
                    end
                end
                OP_INTERNAL, OP_LEAF:
                begin
                    if (tree_done_reg || (next_free_reg >= NODE_CAP_C))
                    begin
                        status_next = STATUS_TREE_ERR;
                    end
                    else if ((op_reg == OP_INTERNAL) && !attach
                             && (count_reg >= STACK_CAP_C))
                    begin
                        status_next = STATUS_TREE_ERR;
                    end
                    else
                    begin
                        // The node after a leaf is the right child of the stack top.
                        if (attach)
                        begin
                            right_we = 1'b1;
                            if (stack_top_reg == '0)
                            begin
                                root_right_next = n_idx;
                            end
                        end
                        node_we        = 1'b1;
                        next_free_next = next_free_reg + 1'b1;
                        last_leaf_next = (op_reg == OP_LEAF);
                        if (op_reg == OP_LEAF)
                        begin
                            node_wd = '{is_leaf: 1'b1, symbol: sym_reg};
                            if (attach)
                            begin
                                count_next = count_dec;
                            end
                            if ((attach ? count_dec : count_reg) == '0)
                            begin
                                tree_done_next = 1'b1;
                                walk_next      = '0;
                            end
                        end
                        else
                        begin
                            // A pop followed by a push replaces the top in place.
                            stack_we = 1'b1;
                            if (attach)
                            begin
                                stack_wa = count_dec[SAW-1:0];
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        if (n_idx == '0)
                        begin
                            root_leaf_next = (op_reg == OP_LEAF);
                            root_sym_next  = sym_reg;
                        end
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    // The stack top is prefetched for the count that the next cycle will see.
    always_comb
    begin
        stack_ra = '0;
        if (count_next != '0)
        begin
            stack_ra = SAW'(count_next - 1'b1);
        end
    end

    // Node table: leaf flag and symbol, read at the walk child.
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[n_idx] <= node_wd;
        end
        rd_node_reg <= node_mem[child];
    end

    // Node table: right-child indexes, written when a pending node is popped.
    always_ff @(posedge clk)
    begin
        if (right_we)
        begin
            right_mem[stack_top_reg] <= n_idx;
        end
        rd_right_reg <= right_mem[child];
    end

    // Pending stack with write-to-read forwarding onto the top register.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= n_idx;
        end
        if (stack_we && (stack_wa == stack_ra))
        begin
            stack_top_reg <= n_idx;
        end
        else
        begin
            stack_top_reg <= stack_mem[stack_ra];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            op_reg  <= op_t'(operation);
            sym_reg <= leaf_symbol;
            bit_reg <= code_bit;
        end
        if (complete)
        begin
            dsym_reg   <= dsym_next;
            svalid_reg <= svalid_next;
            tready_reg <= tree_done_next;
            status_reg <= status_next;
        end
        root_sym_reg   <= root_sym_next;
        root_right_reg <= root_right_next;
        cur_right_reg  <= cur_right_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            wait_reg         <= 1'b0;
            next_free_reg    <= '0;
            count_reg        <= '0;
            tree_done_reg    <= 1'b0;
            last_leaf_reg    <= 1'b0;
            root_leaf_reg    <= 1'b0;
            walk_reg         <= '0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
            wait_reg         <= wait_next;
            next_free_reg    <= next_free_next;
            count_reg        <= count_next;
            tree_done_reg    <= tree_done_next;
            last_leaf_reg    <= last_leaf_next;
            root_leaf_reg    <= root_leaf_next;
            walk_reg         <= walk_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign decoded_symbol = dsym_reg;
    assign symbol_valid   = svalid_reg;
    assign tree_ready     = tready_reg;
    assign status         = status_reg;

endmodule
